[rtl/core/msk_pkg.sv]
// modified soundex key package: types, constants and character classing
// no dependencies; used by every file of the block

package msk_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [CHAR_W-1:0] VOWEL_SYM = 8'h2A;   // '*'
    localparam logic [CHAR_W-1:0] NO_SYM    = 8'h00;

    typedef logic [CHAR_W-1:0] char_t;

    // request kinds handed from front to back
    typedef enum logic
    {
        OP_FIRST,   // first character of a word, copied as is
        OP_NEXT     // later character, carries candidate symbols
    } op_kind_t;

    typedef struct packed
    {
        op_kind_t kind;
        logic     is_end;   // request carries the word's last character
        char_t    sym1;     // held character's symbol, or the first character
        char_t    sym2;     // last character's symbol when is_end
    } msk_op_t;

    typedef enum logic
    {
        BK_SYM1,
        BK_SYM2
    } back_state_t;

    function automatic char_t sym_of(input char_t c);
        char_t s;
        case (c) inside
            "a", "e", "i", "o", "u", "y": s = VOWEL_SYM;
            "b", "f", "p", "v":           s = "1";
            "c", "g", "j", "k", "q", "s": s = "2";
            "d", "t":                     s = "3";
            "l":                          s = "4";
            "m", "n":                     s = "5";
            "r":                          s = "6";
            default:                      s = NO_SYM;
        endcase
        return s;
    endfunction

    function automatic logic vowel_char(input char_t c);
        return sym_of(c) == VOWEL_SYM;
    endfunction

    // candidate symbol of c from its neighbors, before suppression
    function automatic char_t decide_sym(input char_t c, input char_t prev,
                                         input char_t nxt, input logic nxt_is_end);
        char_t s;
        if (c == "e" && nxt_is_end)
        begin
            s = NO_SYM;
        end
        else if ((c == "y" || c == "w" || c == "h") && vowel_char(prev) &&
                 !nxt_is_end && vowel_char(nxt))
        begin
            s = c;
        end
        else
        begin
            s = sym_of(c);
        end
        return s;
    endfunction

endpackage

[rtl/core/msk_if.sv]
// character and key channel interfaces of the modified soundex key block
// depends on msk_pkg

interface msk_char_if
    import msk_pkg::*;
;
    logic  valid;
    logic  ready;
    char_t ch;
    logic  word_end;

    modport source (output valid, output ch, output word_end, input ready);
    modport sink   (input valid, input ch, input word_end, output ready);
endinterface

interface msk_key_if
    import msk_pkg::*;
;
    logic  valid;
    logic  ready;
    char_t code;
    logic  has_code;
    logic  key_end;

    modport source (output valid, output code, output has_code, output key_end,
                    input ready);
    modport sink   (input valid, input code, input has_code, input key_end,
                    output ready);
endinterface

[rtl/core/msk_front.sv]
// front end: accepts characters, keeps lookahead context, forms requests
// depends on msk_pkg and msk_if

module msk_front
    import msk_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    msk_char_if.sink       chars,
    output logic           push_valid,
    input  logic           push_ready,
    output msk_op_t        push_data
);

    char_t held_char_reg, held_char_next;
    logic  held_valid_reg, held_valid_next;
    char_t before_held_reg, before_held_next;
    logic  at_start_reg, at_start_next;

    logic  accept;
    char_t bh_mid;

    assign chars.ready = push_ready;
    assign push_valid  = chars.valid;
    assign accept      = chars.valid && push_ready;

    // context after the held character has been decided
    assign bh_mid = held_valid_reg ? held_char_reg : before_held_reg;

    always_comb
    begin
        push_data.is_end = chars.word_end;
        if (at_start_reg)
        begin
            push_data.kind = OP_FIRST;
            push_data.sym1 = chars.ch;
            push_data.sym2 = NO_SYM;
        end
        else
        begin
            push_data.kind = OP_NEXT;
            push_data.sym1 = held_valid_reg ?
                decide_sym(held_char_reg, before_held_reg, chars.ch, 1'b0) : NO_SYM;
            push_data.sym2 = decide_sym(chars.ch, bh_mid, NO_SYM, 1'b1);
        end
    end

    always_comb
    begin
        held_char_next   = held_char_reg;
        held_valid_next  = held_valid_reg;
        before_held_next = before_held_reg;
        at_start_next    = at_start_reg;
        if (accept)
        begin
            held_char_next = chars.ch;
            if (at_start_reg)
            begin
                before_held_next = chars.ch;
                held_valid_next  = 1'b0;
                at_start_next    = chars.word_end;
            end
            else if (chars.word_end)
            begin
                before_held_next = chars.ch;
                held_valid_next  = 1'b0;
                at_start_next    = 1'b1;
            end
            else
            begin
                before_held_next = bh_mid;
                held_valid_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_char_reg   <= '0;
            held_valid_reg  <= 1'b0;
            before_held_reg <= '0;
            at_start_reg    <= 1'b1;
        end
        else
        begin
            held_char_reg   <= held_char_next;
            held_valid_reg  <= held_valid_next;
            before_held_reg <= before_held_next;
            at_start_reg    <= at_start_next;
        end
    end

endmodule

[rtl/core/msk_queue.sv]
// short request queue between front and back
// depends on msk_pkg

module msk_queue
    import msk_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  msk_op_t push_data,
    output logic    pop_valid,
    input  logic    pop_ready,
    output msk_op_t pop_data
);

    msk_op_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = count_reg != QCNT_W'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/msk_back.sv]
// back end: suppresses repeats, emits key symbols into an output register
// depends on msk_pkg and msk_if

module msk_back
    import msk_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  msk_op_t        pop_data,
    msk_key_if.source      keys
);

    back_state_t state_reg, state_next;
    char_t       last_reg, last_next;
    logic        out_valid_reg;
    char_t       out_code_reg;
    logic        out_has_reg, out_end_reg;

    logic  load_ok;
    logic  emit1, emit2;
    char_t last_mid;
    logic  want;
    char_t res_code;
    logic  res_has, res_end;

    assign load_ok = !out_valid_reg || keys.ready;

    // held symbol is emitted unless absent or a repeat
    assign emit1    = pop_data.kind == OP_NEXT && pop_data.sym1 != NO_SYM &&
                      pop_data.sym1 != last_reg;
    assign last_mid = emit1 ? pop_data.sym1 : last_reg;
    assign emit2    = pop_data.sym2 != NO_SYM && pop_data.sym2 != last_mid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_SYM1:
            begin
                if (pop_valid && load_ok && pop_data.kind == OP_NEXT && emit1 &&
                    pop_data.is_end)
                begin
                    state_next = BK_SYM2;
                end
            end
            BK_SYM2:
            begin
                if (load_ok)
                begin
                    state_next = BK_SYM1;
                end
            end
            default: state_next = BK_SYM1;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        want      = 1'b0;
        pop_ready = 1'b0;
        res_code  = NO_SYM;
        res_has   = 1'b0;
        res_end   = 1'b0;
        last_next = last_reg;
        case (state_reg)
            BK_SYM1:
            begin
                if (pop_data.kind == OP_FIRST)
                begin
                    want      = 1'b1;
                    res_code  = pop_data.sym1;
                    res_has   = 1'b1;
                    res_end   = pop_data.is_end;
                    pop_ready = load_ok;
                    last_next = pop_data.sym1;
                end
                else if (emit1)
                begin
                    want      = 1'b1;
                    res_code  = pop_data.sym1;
                    res_has   = 1'b1;
                    pop_ready = load_ok && !pop_data.is_end;
                    last_next = pop_data.sym1;
                end
                else if (pop_data.is_end)
                begin
                    want      = 1'b1;
                    res_code  = emit2 ? pop_data.sym2 : NO_SYM;
                    res_has   = emit2;
                    res_end   = 1'b1;
                    pop_ready = load_ok;
                    last_next = emit2 ? pop_data.sym2 : last_reg;
                end
                else
                begin
                    // nothing to emit, drop the request
                    pop_ready = 1'b1;
                end
            end
            BK_SYM2:
            begin
                want      = 1'b1;
                res_code  = emit2 ? pop_data.sym2 : NO_SYM;
                res_has   = emit2;
                res_end   = 1'b1;
                pop_ready = load_ok;
                last_next = emit2 ? pop_data.sym2 : last_reg;
            end
            default:
            begin
                want = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_SYM1;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_valid)
            begin
                state_reg <= state_next;
                if (!want || load_ok)
                begin
                    last_reg <= last_next;
                end
            end
            if (pop_valid && want && load_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (keys.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && want && load_ok)
        begin
            out_code_reg <= res_code;
            out_has_reg  <= res_has;
            out_end_reg  <= res_end;
        end
    end

    assign keys.valid    = out_valid_reg;
    assign keys.code     = out_code_reg;
    assign keys.has_code = out_has_reg;
    assign keys.key_end  = out_end_reg;

endmodule

[rtl/core/modified_soundex_key.sv]
// top level of the modified soundex key encoder
// depends on msk_pkg, msk_if, msk_front, msk_queue and msk_back

// usage
// - chars: one lower-case character per request, word_end set on the last
//   character of a word; a word is never empty
// - keys: the key symbols of each word in order; the first request of a key
//   is the word's first character, key_end marks the last request of a key,
//   and a request with has_code low is a bare end marker with code zero
// - each character gives zero, one or two key requests; later characters are
//   held one step so that the next character is known when they are decided
// - the front takes a character every cycle while the four-entry queue has
//   room; the back drains one queue entry per cycle while its output register
//   can load, except that a word's last character that releases two symbols
//   stays in the queue until the back has moved on to the BK_SYM2 state
// - sustained rate is one character per cycle while keys are taken, lower when
//   words end with two symbols; the back's single output register sets this
// - a stalled key receiver holds the output register, the queue fills, and
//   then chars.ready drops; nothing is lost or repeated
// - reset clears the context, the queue and the output register; the next
//   character after reset starts a new word

module modified_soundex_key
    import msk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    msk_char_if.sink  chars,
    msk_key_if.source keys
);

    // front to queue
    logic    push_valid, push_ready;
    msk_op_t push_data;

    // queue to back
    logic    pop_valid, pop_ready;
    msk_op_t pop_data;

    // context tracking and candidate symbols
    msk_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decouples the character stream from key stalls
    msk_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // repeat suppression and key emission
    msk_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .keys      (keys)
    );

endmodule

[rtl/core/msk_checker.sv]
// port-level checks of the modified soundex key encoder, bound to the top
// depends on msk_pkg and modified_soundex_key

module msk_checker
    import msk_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  in_word_end,
    input logic  out_valid,
    input logic  out_ready,
    input char_t out_code,
    input logic  out_has_code,
    input logic  out_key_end
);

    // words whose end has been accepted but whose key is not yet complete
    logic [3:0] open_reg, open_next;
    logic       in_end_acc, out_end_acc;

    assign in_end_acc  = in_valid && in_ready && in_word_end;
    assign out_end_acc = out_valid && out_ready && out_key_end;

    always_comb
    begin
        open_next = open_reg;
        if (in_end_acc && !out_end_acc)
        begin
            open_next = open_reg + 1'b1;
        end
        else if (out_end_acc && !in_end_acc)
        begin
            open_next = open_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_code) &&
        $stable(out_has_code) && $stable(out_key_end))
        else $error("key request changed while stalled");

    a_bare_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_has_code |-> out_key_end)
        else $error("bare end marker without key_end");

    a_bare_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_has_code |-> out_code == NO_SYM)
        else $error("bare end marker with nonzero code");

    a_no_early_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_end_acc |-> open_reg != '0)
        else $error("key ended before its word's last character arrived");

endmodule

bind modified_soundex_key msk_checker u_msk_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (chars.valid),
    .in_ready     (chars.ready),
    .in_word_end  (chars.word_end),
    .out_valid    (keys.valid),
    .out_ready    (keys.ready),
    .out_code     (keys.code),
    .out_has_code (keys.has_code),
    .out_key_end  (keys.key_end)
);

[sim/testbench.sv]
// self-checking testbench for the modified soundex key encoder
// depends on msk_pkg, msk_if and modified_soundex_key; predicts every key request itself

module testbench
    import msk_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_CHARS = 1050;
    localparam int DRAIN_CYCLES = 16;     // leave plenty of time for stray key requests
    localparam int LIMIT_CYCLES = 200000;

    // one character request as the sender sees it
    typedef struct packed
    {
        char_t ch;
        logic  word_end;
    } char_req_t;

    // one key request as the receiver sees it
    typedef struct packed
    {
        char_t code;
        logic  has_code;
        logic  key_end;
    } key_req_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    msk_char_if chars_if ();
    msk_key_if  keys_if ();

    modified_soundex_key u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars_if),
        .keys  (keys_if)
    );

    // character stream waiting to be offered, and key requests still owed
    char_req_t pending_chars[$];
    key_req_t  expected_keys[$];

    int error_count = 0;
    int cycle_count = 0;

    // character pools for the random words
    string vowel_set = "aeiouy";
    string glide_set = "ywh";

    // encoder context mirrored from the accepted characters
    char_t held_char    = '0;   // character waiting for its successor
    logic  held_pending = 1'b0;
    char_t prior_char   = '0;   // character just before the held one
    char_t last_sym     = '0;   // last symbol put into the current key
    logic  word_first   = 1'b1; // next character opens a new word

    // driver and receiver bookkeeping
    char_req_t next_req;
    int        burst_left = 0;
    int        gap_left   = 0;
    int        stall_left = 0;
    int        recv_cycle = 0;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // plain soundex class of a byte: digit, '*' for vowels, zero if unmapped
    function automatic char_t soundex_class(input char_t c);
        char_t s;
        s = NO_SYM;
        if (c == "a" || c == "e" || c == "i" || c == "o" || c == "u" || c == "y")
            s = VOWEL_SYM;
        else if (c == "b" || c == "f" || c == "p" || c == "v")
            s = "1";
        else if (c == "c" || c == "g" || c == "j" || c == "k" || c == "q" || c == "s")
            s = "2";
        else if (c == "d" || c == "t")
            s = "3";
        else if (c == "l")
            s = "4";
        else if (c == "m" || c == "n")
            s = "5";
        else if (c == "r")
            s = "6";
        return s;
    endfunction

    // symbol of c given its neighbors; updates last_sym when one is emitted
    function automatic void pick_symbol(input char_t c, input char_t prev,
                                        input char_t nxt, input logic nxt_is_end,
                                        output logic emit, output char_t s);
        logic glide;
        emit = 1'b0;
        s    = NO_SYM;
        // a word-final e vanishes
        if (c == "e" && nxt_is_end)
            return;
        // y, w or h squeezed between two vowels stays literal
        glide = (c == "y" || c == "w" || c == "h") &&
                soundex_class(prev) == VOWEL_SYM &&
                !nxt_is_end && soundex_class(nxt) == VOWEL_SYM;
        s = glide ? c : soundex_class(c);
        // unmapped bytes and repeats of the last symbol give nothing
        if (s == NO_SYM || s == last_sym)
        begin
            s = NO_SYM;
            return;
        end
        last_sym = s;
        emit     = 1'b1;
    endfunction

    // append one owed key request
    task automatic owe_key(input char_t code, input logic has, input logic last);
        key_req_t k;
        k.code     = code;
        k.has_code = has;
        k.key_end  = last;
        expected_keys.insert(expected_keys.size(), k);
    endtask

    // work out the key requests caused by one accepted character
    task automatic predict_keys(input char_t c, input logic last);
        logic  emit;
        char_t s;
        if (word_first)
        begin
            // first character goes out untouched
            owe_key(c, 1'b1, last);
            last_sym     = c;
            prior_char   = c;
            held_pending = 1'b0;
            word_first   = last;
        end
        else
        begin
            // the held character is decided now that its successor is known
            if (held_pending)
            begin
                pick_symbol(held_char, prior_char, c, 1'b0, emit, s);
                if (emit)
                    owe_key(s, 1'b1, 1'b0);
                prior_char = held_char;
            end
            held_char    = c;
            held_pending = 1'b1;
            if (last)
            begin
                // last character closes the key, with a bare marker if it adds nothing
                pick_symbol(c, prior_char, NO_SYM, 1'b1, emit, s);
                if (emit)
                    owe_key(s, 1'b1, 1'b1);
                else
                    owe_key(NO_SYM, 1'b0, 1'b1);
                held_pending = 1'b0;
                prior_char   = c;
                word_first   = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_char(input char_t c, input logic last);
        char_req_t r;
        r.ch       = c;
        r.word_end = last;
        pending_chars.insert(pending_chars.size(), r);
    endtask

    task automatic add_word(input string w);
        for (int i = 0; i < w.len(); i++)
            queue_char(char_t'(w[i]), i == w.len() - 1);
    endtask

    // mostly lower-case letters, heavy on vowels and glides, some raw bytes
    function automatic char_t rand_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return char_t'($urandom_range(0, 255));
        if (r < 30)
            return char_t'(vowel_set[$urandom_range(0, 5)]);
        if (r < 45)
            return char_t'(glide_set[$urandom_range(0, 2)]);
        return char_t'(8'd97 + $urandom_range(0, 25));
    endfunction

    // ------------------------------------------------------------------
    // clock, cycle counter and watchdog
    // ------------------------------------------------------------------

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
            @(posedge clk);
        $display("[modified_soundex_key] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // character driver: bursts of requests with random gaps
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_if.valid    <= 1'b0;
            chars_if.ch       <= '0;
            chars_if.word_end <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            // a request taken at this edge updates the predicted context
            if (chars_if.valid && chars_if.ready)
                predict_keys(chars_if.ch, chars_if.word_end);

            // an offered request stays put until the block takes it
            if (!chars_if.valid || chars_if.ready)
            begin
                if (gap_left > 0 || pending_chars.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    chars_if.valid <= 1'b0;
                end
                else
                begin
                    next_req = pending_chars.pop_front();
                    chars_if.valid    <= 1'b1;
                    chars_if.ch       <= next_req.ch;
                    chars_if.word_end <= next_req.word_end;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        // new burst; a third of them follow on with no gap
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // key receiver: short random stalls, calm stretches, two long hold-offs
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys_if.ready <= 1'b0;
            stall_left = 0;
            recv_cycle = 0;
        end
        else
        begin
            recv_cycle++;
            // long hold-off while characters keep coming: the queue fills
            // and the block has to drop chars.ready
            if (recv_cycle == 300 || recv_cycle == 1800)
                stall_left = 150;

            if (stall_left > 0)
            begin
                stall_left--;
                keys_if.ready <= 1'b0;
            end
            else if (recv_cycle[8:7] == 2'b00)
            begin
                // calm window: ready once any running stall is over
                keys_if.ready <= 1'b1;
            end
            else if ($urandom_range(0, 99) < 20)
            begin
                stall_left = $urandom_range(0, 3);
                keys_if.ready <= 1'b0;
            end
            else
            begin
                keys_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // key monitor: each taken request against the oldest prediction
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && keys_if.valid && keys_if.ready)
        begin
            if (expected_keys.size() == 0)
            begin
                $error("key request with none predicted: code %h has_code %b key_end %b",
                       keys_if.code, keys_if.has_code, keys_if.key_end);
                error_count++;
            end
            else
            begin
                if (keys_if.code !== expected_keys[0].code)
                begin
                    $error("code: expected %h, got %h", expected_keys[0].code, keys_if.code);
                    error_count++;
                end
                if (keys_if.has_code !== expected_keys[0].has_code)
                begin
                    $error("has_code: expected %b, got %b",
                           expected_keys[0].has_code, keys_if.has_code);
                    error_count++;
                end
                if (keys_if.key_end !== expected_keys[0].key_end)
                begin
                    $error("key_end: expected %b, got %b",
                           expected_keys[0].key_end, keys_if.key_end);
                    error_count++;
                end
                void'(expected_keys.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------

    initial
    begin : main_flow
        int target;
        int len;
        char_t c;

        chars_if.valid    = 1'b0;
        chars_if.ch       = '0;
        chars_if.word_end = 1'b0;
        keys_if.ready     = 1'b0;

        // directed words
        add_word("a");                  // one-character word
        queue_char(8'hFF, 1'b1);        // top byte as a whole word
        add_word("bake");               // final e dropped, bare end marker
        add_word("aha");                // h between vowels kept literal
        queue_char("b", 1'b0);          // zero byte and high byte inside a word
        queue_char(8'h00, 1'b0);
        queue_char(8'h80, 1'b0);
        queue_char("p", 1'b1);
        add_word("pbf");                // repeated digit suppressed at the end
        add_word("oyw");                // y after a vowel but not before one
        add_word("xQz");                // nothing after the first maps
        add_word("ewe");                // w between e's, final e dropped

        // random words: short ones mostly, a few long ones
        target = pending_chars.size() + RANDOM_CHARS;
        while (pending_chars.size() < target)
        begin
            case ($urandom_range(0, 19))
                0, 1:    len = 1;
                2:       len = $urandom_range(8, 12);
                default: len = $urandom_range(2, 7);
            endcase
            for (int i = 0; i < len; i++)
            begin
                c = rand_char();
                // favor a closing e so its drop rule gets plenty of hits
                if (i == len - 1 && len > 1 && $urandom_range(0, 3) == 0)
                    c = "e";
                queue_char(c, i == len - 1);
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // all characters taken and every predicted key request seen
        while (pending_chars.size() != 0 || chars_if.valid || expected_keys.size() != 0)
            @(posedge clk);
        // stray requests after the last key would show up here
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("[modified_soundex_key] OK");
        else
            $display("[modified_soundex_key] ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/core/msk_pkg.sv
rtl/core/msk_if.sv
rtl/core/msk_front.sv
rtl/core/msk_queue.sv
rtl/core/msk_back.sv
rtl/core/modified_soundex_key.sv
rtl/core/msk_checker.sv
sim/testbench.sv
